// ===== hdl/rlp_pkg.sv =====
// rlp_pkg: types and constants shared by the raster line run-length parser
// no dependencies
`timescale 1ns / 1ps

package rlp_pkg;

  localparam int unsigned CountBitsDef = 16;

  // register indexes of the configuration port
  localparam logic [1:0] REG_PIXEL_FORMAT    = 2'd0;
  localparam logic [1:0] REG_PIXELS_PER_LINE = 2'd1;
  localparam logic [1:0] REG_LINES_PER_PAGE  = 2'd2;

  // pixel format codes
  localparam logic [1:0] FMT_MONO = 2'd0;

  // byte class codes
  localparam logic [1:0] CLS_LINE_REPEAT = 2'd0;
  localparam logic [1:0] CLS_RUN_HEADER  = 2'd1;
  localparam logic [1:0] CLS_REPEAT      = 2'd2;
  localparam logic [1:0] CLS_LITERAL     = 2'd3;

  typedef enum logic [3:0] {
    PH_LINE    = 4'b0001,
    PH_RUN     = 4'b0010,
    PH_REPEAT  = 4'b0100,
    PH_LITERAL = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [15:0] pixels_per_line;
    logic [15:0] lines_per_page;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  byte_class;
    logic        line_done;
    logic        page_done;
    logic        error;
    logic [15:0] line_number;
    logic [15:0] pixel_position;
  } result_t;

endpackage

// ===== hdl/rlp_if.sv =====
// rlp_if: valid/ready channel interfaces for bytes, results and register writes
// no dependencies
`timescale 1ns / 1ps

interface rlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rlp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_class;
  logic        line_done;
  logic        page_done;
  logic        error;
  logic [15:0] line_number;
  logic [15:0] pixel_position;
  modport source (output valid, output byte_class, output line_done, output page_done,
                  output error, output line_number, output pixel_position, input ready);
  modport sink (input valid, input byte_class, input line_done, input page_done,
                input error, input line_number, input pixel_position, output ready);
endinterface

interface rlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rlp_cfg_regs.sv =====
// rlp_cfg_regs: configuration registers written over the register request channel
// depends on rlp_pkg and rlp_cfg_if
`timescale 1ns / 1ps

module rlp_cfg_regs
  import rlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rlp_cfg_if.sink     cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PIXEL_FORMAT:    cfg_d.pixel_format    = cfg_i.data[1:0];
        REG_PIXELS_PER_LINE: cfg_d.pixels_per_line = cfg_i.data;
        REG_LINES_PER_PAGE:  cfg_d.lines_per_page  = cfg_i.data;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pixel_format: FMT_MONO, pixels_per_line: 16'd1, lines_per_page: 16'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/rlp_decode.sv =====
// rlp_decode: parse state, pixel and line counters, result for one byte per cycle while step_i is high
// depends on rlp_pkg
`timescale 1ns / 1ps

module rlp_decode
  import rlp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  localparam logic [16:0] SatLim =
    (COUNT_BITS >= 16) ? 17'd65535 : 17'((64'd1 << COUNT_BITS) - 64'd1);

  phase_e      phase_q, phase_d;
  logic [16:0] pix_q, pix_d;
  logic [8:0]  lrc_q, lrc_d;
  logic [7:0]  rr_q, rr_d;
  logic [16:0] lines_q, lines_d;
  logic [1:0]  bic_q, bic_d;
  logic        err_q, err_d;

  logic        mono, rep, color_done, line_end, bad, ldone, pdone;
  logic [1:0]  bic_inc, cls;
  logic [10:0] add;
  logic [7:0]  rr_next;
  logic [16:0] sum, target, lines_sum, lines_out;

  assign mono       = (cfg_i.pixel_format == FMT_MONO);
  assign rep        = (phase_q == PH_REPEAT);
  assign bic_inc    = bic_q + 2'd1;
  assign color_done = cfg_i.pixel_format[1] ? (bic_inc == 2'd3) : (bic_inc != 2'd0);
  assign add        = rep ? (mono ? {rr_q, 3'b000} : {3'b000, rr_q})
                          : (mono ? 11'd8 : 11'd1);
  assign rr_next    = rep ? 8'd0 : ((rr_q != 8'd0) ? rr_q - 8'd1 : 8'd0);
  assign sum        = pix_q + {6'd0, add};
  assign target     = mono ? (({1'b0, cfg_i.pixels_per_line} + 17'd7) & ~17'd7)
                           : {1'b0, cfg_i.pixels_per_line};
  assign line_end   = (sum >= {1'b0, cfg_i.pixels_per_line});
  assign bad        = (sum != target) || (!rep && (rr_next != 8'd0));
  assign lines_sum  = lines_q + {8'd0, lrc_q};

  always_comb begin
    phase_d = phase_q;
    pix_d   = pix_q;
    lrc_d   = lrc_q;
    rr_d    = rr_q;
    lines_d = lines_q;
    bic_d   = bic_q;
    err_d   = err_q;
    ldone   = 1'b0;
    pdone   = 1'b0;
    cls     = CLS_LINE_REPEAT;
    case (phase_q)
      PH_LINE: begin
        cls     = CLS_LINE_REPEAT;
        pix_d   = '0;
        lrc_d   = {1'b0, byte_i} + 9'd1;
        bic_d   = 2'd0;
        phase_d = PH_RUN;
      end
      PH_RUN: begin
        cls   = CLS_RUN_HEADER;
        bic_d = 2'd0;
        if (byte_i[7]) begin
          rr_d    = 8'(9'd257 - {1'b0, byte_i});
          phase_d = PH_LITERAL;
        end else begin
          rr_d    = byte_i + 8'd1;
          phase_d = PH_REPEAT;
        end
      end
      PH_REPEAT, PH_LITERAL: begin
        cls   = rep ? CLS_REPEAT : CLS_LITERAL;
        bic_d = color_done ? 2'd0 : bic_inc;
        if (color_done) begin
          rr_d  = rr_next;
          pix_d = sum;
          if (line_end) begin
            if (bad) begin
              err_d = 1'b1;
            end else begin
              ldone   = 1'b1;
              pdone   = (lines_sum >= {1'b0, cfg_i.lines_per_page});
              lines_d = pdone ? 17'd0 : lines_sum;
            end
            phase_d = PH_LINE;
          end else if (rep || (rr_next == 8'd0)) begin
            phase_d = PH_RUN;
          end
        end
      end
      default: begin
        phase_d = PH_LINE;
      end
    endcase
  end

  assign lines_out = ldone ? lines_sum : lines_q;

  assign res_o.byte_class     = cls;
  assign res_o.line_done      = ldone;
  assign res_o.page_done      = pdone;
  assign res_o.error          = err_d;
  assign res_o.line_number    = (lines_out > SatLim) ? SatLim[15:0] : lines_out[15:0];
  assign res_o.pixel_position = (pix_d > SatLim) ? SatLim[15:0] : pix_d[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
      pix_q   <= '0;
      lrc_q   <= '0;
      rr_q    <= '0;
      lines_q <= '0;
      bic_q   <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pix_q   <= pix_d;
      lrc_q   <= lrc_d;
      rr_q    <= rr_d;
      lines_q <= lines_d;
      bic_q   <= bic_d;
      err_q   <= err_d;
    end
  end

  // sticky error
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |=> err_q)
    else $error("error flag cleared");

  // a finished line returns to the line repeat byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_i && ldone) |=> (phase_q == PH_LINE))
    else $error("line end without return to line start");

  // colour byte counter never rests at its top value
  assert property (@(posedge clk_i) disable iff (!rst_ni) bic_q != 2'd3)
    else $error("colour byte counter overrun");

  // completed line count never reaches bit 16
  assert property (@(posedge clk_i) disable iff (!rst_ni) !lines_q[16])
    else $error("line count overflow");

  // page end only with a completed line
  assert property (@(posedge clk_i) disable iff (!rst_ni) pdone |-> ldone)
    else $error("page end without line end");

endmodule

// ===== hdl/raster_line_rle_parser.sv =====
// raster_line_rle_parser: top level with input stage, decoder and result register
// depends on rlp_pkg, rlp_if, rlp_cfg_regs and rlp_decode
`timescale 1ns / 1ps

// Decodes a run-length coded raster page body, one byte per request.
// data_i carries compressed bytes; result_o returns one result per byte:
// its class, line and page end flags, the sticky error flag and the line
// and pixel counts, saturated to COUNT_BITS (at most 16 bits).
// cfg_i writes pixel_format (0), pixels_per_line (1) and lines_per_page (2);
// it is always ready, and writes belong to idle periods.
// A byte passes one input register, then the parse step, which updates
// state and loads the result register in the same cycle. Throughput is one
// byte per cycle while the receiver takes results, set by the parse step
// feeding back into the counters.
// Reset clears the parse state, counters and error flag, and sets the
// registers to mono, one pixel per line, one line per page.
// When the receiver stalls the result register holds; an empty input
// register takes one more byte, then data_i.ready drops until results drain.

module raster_line_rle_parser
  import rlp_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlp_cfg_if.sink     cfg_i,
  rlp_byte_if.sink    data_i,
  rlp_result_if.source result_o
);

  cfg_t    cfg;
  result_t res;

  logic       s1_vld_q, s1_vld_d;
  logic [7:0] s1_byte_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_res_q;
  logic       out_free, fire, in_acc;

  rlp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rlp_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (fire),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  assign out_free     = !out_vld_q || result_o.ready;
  assign fire         = s1_vld_q && out_free;
  assign data_i.ready = !s1_vld_q || fire;
  assign in_acc       = data_i.valid && data_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (fire) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_i.data_byte;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.byte_class     = out_res_q.byte_class;
  assign result_o.line_done      = out_res_q.line_done;
  assign result_o.page_done      = out_res_q.page_done;
  assign result_o.error          = out_res_q.error;
  assign result_o.line_number    = out_res_q.line_number;
  assign result_o.pixel_position = out_res_q.pixel_position;

endmodule

// ===== tb/raster_line_rle_parser_tb.sv =====
// raster_line_rle_parser_tb: self-checking bench for the raster line run-length parser
// drives bytes and register writes, predicts every result and compares field by field
// depends on rlp_pkg, rlp_if and raster_line_rle_parser
`timescale 1ns / 1ps

module raster_line_rle_parser_tb;
  import rlp_pkg::*;

  localparam logic [1:0] FMT_GRAY     = 2'd1;
  localparam logic [1:0] FMT_RGB      = 2'd2;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int unsigned REPORT_MAX  = (CountBitsDef >= 16) ? 32'hFFFF
                                        : (32'd1 << CountBitsDef) - 1;
  localparam int unsigned ITEMS        = 1150;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_LIMIT  = 2000;

  // mono, one pixel per line: good line, overshoot, two leftover-literal cases, good line
  localparam logic [15*8-1:0] MONO_SEQ = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF,
                                          8'h00, 8'h80, 8'h55, 8'h00, 8'hFF, 8'h01,
                                          8'h00, 8'h00, 8'h0F};
  // gray, three pixels per line: literal line ending the page, then a repeat line
  localparam logic [8*8-1:0] GRAY_SEQ = {8'h01, 8'hFE, 8'h10, 8'h20, 8'h30,
                                         8'h00, 8'h02, 8'h77};

  logic clk = 1'b0;
  logic rst_n;

  rlp_cfg_if    cfg_if ();
  rlp_byte_if   byte_if ();
  rlp_result_if res_if ();

  raster_line_rle_parser DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .data_i  (byte_if),
    .result_o(res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  byte_q [$];
  result_t     decoded_q [$];
  bit          no_idle = 1'b0;
  int unsigned fail_count = 0;
  int unsigned stim_count = 0;
  int unsigned stall_cycles;

  // register copies
  logic [1:0]  fmt_cfg;
  logic [15:0] ppl_cfg;
  logic [15:0] lpp_cfg;

  // decoder state
  logic [1:0]  dec_phase;
  int unsigned dec_pixels;
  int unsigned dec_repeat;
  int unsigned dec_run_left;
  int unsigned dec_lines;
  int unsigned dec_color_byte;
  bit          dec_err;

  function automatic logic [15:0] clamp_count(input int unsigned v);
    return (v > REPORT_MAX) ? 16'(REPORT_MAX) : 16'(v);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    result_t     r;
    logic [1:0]  cls;
    int unsigned bpc, unit, add, sum, target, lines_shown;
    bit          ldone, pdone;
    cls   = dec_phase;
    ldone = 1'b0;
    pdone = 1'b0;
    case (cls)
      CLS_LINE_REPEAT: begin
        dec_pixels     = 0;
        dec_repeat     = 32'(b) + 1;
        dec_color_byte = 0;
        dec_phase      = CLS_RUN_HEADER;
      end
      CLS_RUN_HEADER: begin
        if (b > 8'd127) begin
          dec_run_left = 257 - 32'(b);
          dec_phase    = CLS_LITERAL;
        end else begin
          dec_run_left = 32'(b) + 1;
          dec_phase    = CLS_REPEAT;
        end
        dec_color_byte = 0;
      end
      default: begin
        bpc  = fmt_cfg[1] ? 3 : 1;
        unit = (fmt_cfg == FMT_MONO) ? 8 : 1;
        dec_color_byte = (dec_color_byte + 1) % 4;
        if (dec_color_byte >= bpc) begin
          dec_color_byte = 0;
          if (cls == CLS_REPEAT) begin
            add          = dec_run_left * unit;
            dec_run_left = 0;
          end else begin
            add = unit;
            if (dec_run_left > 0) dec_run_left--;
          end
          sum        = dec_pixels + add;
          dec_pixels = sum;
          if (sum >= 32'(ppl_cfg)) begin
            // mono lines are whole bytes, so the length rounds up to a multiple of 8
            target = (fmt_cfg == FMT_MONO) ? ((32'(ppl_cfg) + 7) & ~32'd7) : 32'(ppl_cfg);
            if (sum != target || (cls == CLS_LITERAL && dec_run_left != 0)) begin
              dec_err = 1'b1;
            end else begin
              ldone     = 1'b1;
              dec_lines = dec_lines + dec_repeat;
              if (dec_lines >= 32'(lpp_cfg)) pdone = 1'b1;
            end
            dec_phase = CLS_LINE_REPEAT;
          end else if (cls == CLS_REPEAT || dec_run_left == 0) begin
            dec_phase = CLS_RUN_HEADER;
          end
        end
      end
    endcase
    lines_shown = dec_lines;
    if (pdone) dec_lines = 0;
    r.byte_class     = cls;
    r.line_done      = ldone;
    r.page_done      = pdone;
    r.error          = dec_err;
    r.line_number    = clamp_count(lines_shown);
    r.pixel_position = clamp_count(dec_pixels);
    decoded_q.push_back(r);
  endfunction

  // byte channel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= 8'h00;
    end else begin
      if (byte_if.valid && byte_if.ready) decode_byte(byte_if.data_byte);
      if (!byte_if.valid || byte_if.ready) begin
        if (byte_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          byte_if.data_byte <= byte_q.pop_front();
          byte_if.valid     <= 1'b1;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual class %0d",
                   $time, res_if.byte_class);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("byte_class", 16'(want.byte_class), 16'(res_if.byte_class));
          check_field("line_done", 16'(want.line_done), 16'(res_if.line_done));
          check_field("page_done", 16'(want.page_done), 16'(res_if.page_done));
          check_field("error", 16'(want.error), 16'(res_if.error));
          check_field("line_number", want.line_number, res_if.line_number);
          check_field("pixel_position", want.pixel_position, res_if.pixel_position);
        end
      end
      res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)
                 || (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    byte_q.push_back(b);
    stim_count++;
  endtask

  task automatic queue_colors(input int unsigned n);
    repeat (n) queue_byte(8'($urandom));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_q.size() != 0 || byte_if.valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PIXEL_FORMAT:    fmt_cfg = val[1:0];
      REG_PIXELS_PER_LINE: ppl_cfg = val;
      REG_LINES_PER_PAGE:  lpp_cfg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic start_phase(input logic [1:0] fmt, input logic [15:0] ppl,
                             input logic [15:0] lpp);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, 16'(fmt));
    write_reg(REG_PIXELS_PER_LINE, ppl);
    write_reg(REG_LINES_PER_PAGE, lpp);
  endtask

  // feed bytes one request at a time until the parser wants a line-repeat byte
  task automatic resync();
    while (dec_phase != CLS_LINE_REPEAT) begin
      queue_byte((dec_phase == CLS_RUN_HEADER) ? 8'h7F : 8'($urandom));
      wait_idle();
    end
  endtask

  // one line of runs for the current settings; broken lines overshoot the length
  // or announce more literal colours than the line has room for
  task automatic queue_line(input int rep, input int unsigned lit_pct, input bit broken);
    int unsigned need, bpc, k, ext, cap, r;
    need = (fmt_cfg == FMT_MONO) ? (32'(ppl_cfg) + 7) / 8 : 32'(ppl_cfg);
    if (need == 0) need = 1;
    bpc = fmt_cfg[1] ? 3 : 1;
    if (rep >= 0) begin
      queue_byte(8'(rep));
    end else begin
      r = $urandom_range(0, 9);
      queue_byte((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
    end
    while (need > 0) begin
      if (broken && need <= 120) begin
        ext = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1) begin
          queue_byte(8'(257 - (need + ext)));
          queue_colors(need * bpc);
        end else begin
          queue_byte(8'(need + ext - 1));
          queue_colors(bpc);
        end
        need = 0;
      end else begin
        cap = (need < 128) ? need : 128;
        if (need >= 2 && $urandom_range(1, 100) <= lit_pct) begin
          k = $urandom_range(2, (need < 129) ? need : 129);
          queue_byte(8'(257 - k));
          queue_colors(k * bpc);
        end else begin
          k = $urandom_range(1, cap);
          queue_byte(8'(k - 1));
          queue_colors(bpc);
        end
        need = need - k;
      end
    end
  endtask

  initial begin
    int          phase_idx, sel;
    logic [1:0]  fmt;
    logic [15:0] ppl, lpp;

    rst_n             = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_PIXEL_FORMAT;
    cfg_if.data       = 16'h0000;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    res_if.ready      = 1'b0;
    fmt_cfg           = FMT_MONO;
    ppl_cfg           = 16'd1;
    lpp_cfg           = 16'd1;
    dec_phase         = CLS_LINE_REPEAT;
    dec_pixels        = 0;
    dec_repeat        = 0;
    dec_run_left      = 0;
    dec_lines         = 0;
    dec_color_byte    = 0;
    dec_err           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    start_phase(FMT_MONO, 16'd1, 16'd1);
    for (int i = 14; i >= 0; i--) queue_byte(MONO_SEQ[i*8 +: 8]);
    start_phase(FMT_GRAY, 16'd3, 16'd2);
    for (int i = 7; i >= 0; i--) queue_byte(GRAY_SEQ[i*8 +: 8]);
    stim_count = 0;

    // line count past the counter width, no idling on either side
    start_phase(FMT_GRAY, 16'd1, 16'hFFFF);
    no_idle = 1'b1;
    repeat (257) queue_line(255, 0, 1'b0);
    wait_idle();
    no_idle = 1'b0;

    // longest mono line, pixel count saturates on its last byte
    start_phase(FMT_MONO, 16'hFFFF, 16'd0);
    queue_byte(8'h00);
    repeat (64) begin
      queue_byte(8'h7F);
      queue_colors(1);
    end

    phase_idx = 0;
    while (stim_count < ITEMS || phase_idx < 6) begin
      fmt = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (phase_idx % 6 == 2)  ppl = 16'd0;
      else if (sel < 8)        ppl = 16'($urandom_range(1, 12));
      else                     ppl = 16'($urandom_range(13, 40));
      lpp = 16'($urandom_range(0, 5));
      if (phase_idx == 5) fmt = FMT_RGB;
      start_phase(fmt, ppl, lpp);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      resync();
      repeat ($urandom_range(1, 3)) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          queue_line(-1, 40, 1'b0);
        end else if (sel < 92) begin
          queue_line(-1, 40, 1'b1);
        end else begin
          // noise, then back to a line start
          repeat ($urandom_range(1, 10)) queue_colors(1);
          wait_idle();
          resync();
        end
      end
      phase_idx++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
